// ===== rtl/ir2rgba_pkg.sv =====
// Shared types, constants and helper functions for the indexed raster to RGBA core.
package ir2rgba_pkg;

  localparam int DefPaletteDepth = 256;
  localparam int DefCoordBits    = 16;

  localparam int CfgW   = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [7:0] AlphaClear  = 8'h00;
  localparam logic [7:0] AlphaOpaque = 8'hff;
  localparam logic [1:0] PassLast    = 2'd3;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_REGION_LEFT   = 3'd1,
    REG_REGION_TOP    = 3'd2,
    REG_REGION_WIDTH  = 3'd3,
    REG_REGION_HEIGHT = 3'd4,
    REG_INTERLACED    = 3'd5,
    REG_TRANSP_ON     = 3'd6,
    REG_TRANSP_COLOR  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] frame_width;
    logic [CfgW-1:0] region_left;
    logic [CfgW-1:0] region_top;
    logic [CfgW-1:0] region_width;
    logic [CfgW-1:0] region_height;
    logic            interlaced;
    logic            transparency_on;
    logic [7:0]      transparent_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CfgW:0]   col_sum;
    logic [CfgW-1:0] row_sum;
    logic            last;
  } rast_pos_t;

  function automatic logic [3:0] pass_start(input logic [1:0] p);
    logic [3:0] s;
    case (p)
      2'd0:    s = 4'd0;
      2'd1:    s = 4'd4;
      2'd2:    s = 4'd2;
      2'd3:    s = 4'd1;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] pass_step(input logic [1:0] p);
    logic [3:0] s;
    case (p)
      2'd0:    s = 4'd8;
      2'd1:    s = 4'd8;
      2'd2:    s = 4'd4;
      2'd3:    s = 4'd2;
      default: s = 4'd8;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ir2rgba_cfg.sv =====
// APB-style configuration register bank.
module ir2rgba_cfg
  import ir2rgba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width       <= CfgW'(1);
      cfg_q.region_left       <= '0;
      cfg_q.region_top        <= '0;
      cfg_q.region_width      <= CfgW'(1);
      cfg_q.region_height     <= CfgW'(1);
      cfg_q.interlaced        <= 1'b0;
      cfg_q.transparency_on   <= 1'b0;
      cfg_q.transparent_color <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:   cfg_q.frame_width       <= pwdata[CfgW-1:0];
        REG_REGION_LEFT:   cfg_q.region_left       <= pwdata[CfgW-1:0];
        REG_REGION_TOP:    cfg_q.region_top        <= pwdata[CfgW-1:0];
        REG_REGION_WIDTH:  cfg_q.region_width      <= pwdata[CfgW-1:0];
        REG_REGION_HEIGHT: cfg_q.region_height     <= pwdata[CfgW-1:0];
        REG_INTERLACED:    cfg_q.interlaced        <= pwdata[0];
        REG_TRANSP_ON:     cfg_q.transparency_on   <= pwdata[0];
        REG_TRANSP_COLOR:  cfg_q.transparent_color <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:   prdata = DataW'(cfg_q.frame_width);
      REG_REGION_LEFT:   prdata = DataW'(cfg_q.region_left);
      REG_REGION_TOP:    prdata = DataW'(cfg_q.region_top);
      REG_REGION_WIDTH:  prdata = DataW'(cfg_q.region_width);
      REG_REGION_HEIGHT: prdata = DataW'(cfg_q.region_height);
      REG_INTERLACED:    prdata = DataW'(cfg_q.interlaced);
      REG_TRANSP_ON:     prdata = DataW'(cfg_q.transparency_on);
      REG_TRANSP_COLOR:  prdata = DataW'(cfg_q.transparent_color);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/ir2rgba_palette.sv =====
// Palette RAM with registered read; out-of-range indices read black.
module ir2rgba_palette
  import ir2rgba_pkg::*;
#(
  parameter int Depth = DefPaletteDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  logic       re_i,
  input  logic [7:0] addr_i,
  input  rgb_t       wdata_i,
  output rgb_t       rdata_o
);

  localparam int AW = $clog2(Depth);

  rgb_t mem [Depth];
  rgb_t rdata_q;
  logic hit_q;
  logic hit;

  assign hit     = {1'b0, addr_i} < 9'(Depth);
  assign rdata_o = hit_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (we_i && hit) begin
      mem[addr_i[AW-1:0]] <= wdata_i;
    end
    if (re_i && hit) begin
      rdata_q <= mem[addr_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (re_i) begin
      hit_q <= hit;
    end
  end

endmodule

// ===== rtl/ir2rgba_raster.sv =====
// Column, row and interlace pass counters for the sub-image raster walk.
module ir2rgba_raster
  import ir2rgba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      adv_i,
  output rast_pos_t pos_o
);

  logic [CfgW-1:0] col_q, col_d;
  logic [CfgW-1:0] row_q, row_d;
  logic [1:0]      pass_q, pass_d;

  logic [CfgW-1:0] w, h;
  logic [CfgW:0]   col_inc;
  logic [CfgW:0]   r;
  logic [1:0]      p;
  logic            found;
  logic            last;

  assign w       = (cfg_i.region_width == '0) ? CfgW'(1) : cfg_i.region_width;
  assign h       = (cfg_i.region_height == '0) ? CfgW'(1) : cfg_i.region_height;
  assign col_inc = {1'b0, col_q} + (CfgW+1)'(1);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pass_d = pass_q;
    last   = 1'b0;
    found  = 1'b0;
    p      = pass_q;
    r      = '0;
    if (col_inc < {1'b0, w}) begin
      col_d = col_inc[CfgW-1:0];
    end else begin
      col_d = '0;
      if (!cfg_i.interlaced) begin
        r = {1'b0, row_q} + (CfgW+1)'(1);
        if (r < {1'b0, h}) begin
          row_d = r[CfgW-1:0];
        end else begin
          last = 1'b1;
        end
      end else begin
        r = {1'b0, row_q} + (CfgW+1)'(pass_step(pass_q));
        for (int i = 0; i < 4; i++) begin
          if (!found && !last) begin
            if (r < {1'b0, h}) begin
              found = 1'b1;
            end else if (p == PassLast) begin
              last = 1'b1;
            end else begin
              p = p + 2'd1;
              r = (CfgW+1)'(pass_start(p));
            end
          end
        end
        if (found) begin
          row_d  = r[CfgW-1:0];
          pass_d = p;
        end
      end
    end
    if (last) begin
      col_d  = '0;
      row_d  = '0;
      pass_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else if (adv_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

  assign pos_o.col_sum = {1'b0, cfg_i.region_left} + {1'b0, col_q};
  assign pos_o.row_sum = cfg_i.region_top + row_q;
  assign pos_o.last    = last;

endmodule

// ===== rtl/indexed_raster_to_rgba_deinterlace_core.sv =====
// Pipeline: palette read, then offset multiply, each registered before result valid.
// Throughput: one item per cycle when not stalled; palette RAM and counters keep up.
// Palette writes take effect at their input transfer and give no result.
// Reset: asynchronous, active low; clears counters, pipeline valids and config registers to defaults.
// Palette contents are undefined after reset until written.
module indexed_raster_to_rgba_deinterlace_core
  import ir2rgba_pkg::*;
#(
  parameter int PALETTE_DEPTH = DefPaletteDepth,
  parameter int COORD_BITS    = DefCoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [7:0]            color_index_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [31:0]           pixel_offset_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o,
  output logic                  outside_frame_o,
  output logic                  last_pixel_o
);

  cfg_t      cfg;
  rast_pos_t pos;
  rgb_t      pal_rd;
  rgb_t      pal_wr;

  logic in_xfer, px_xfer, pal_we;
  logic s1_adv, s2_ld;
  logic v1_q, v2_q;

  logic [COORD_BITS-1:0] x1_q, y1_q;
  logic                  out1_q, last1_q, clr1_q;

  logic [COORD_BITS+CfgW-1:0] prod;

  logic [COORD_BITS-1:0] x2_q, y2_q;
  logic [31:0]           off2_q;
  rgb_t                  rgb2_q;
  logic                  out2_q, last2_q, clr2_q;

  ir2rgba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s2_ld      = !v2_q || out_ready_i;
  assign s1_adv     = v1_q && s2_ld;
  assign in_ready_o = !v1_q || s2_ld;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign px_xfer    = in_xfer && (op_e'(op_i) == OP_PIXEL);
  assign pal_we     = in_xfer && (op_e'(op_i) == OP_PAL_WRITE);

  assign pal_wr.red   = red_in_i;
  assign pal_wr.green = green_in_i;
  assign pal_wr.blue  = blue_in_i;

  ir2rgba_raster u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (px_xfer),
    .pos_o  (pos)
  );

  ir2rgba_palette #(
    .Depth (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pal_we),
    .re_i    (px_xfer),
    .addr_i  (color_index_i),
    .wdata_i (pal_wr),
    .rdata_o (pal_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (px_xfer) begin
        v1_q <= 1'b1;
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
      if (s1_adv) begin
        v2_q <= 1'b1;
      end else if (out_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (px_xfer) begin
      x1_q    <= pos.col_sum[COORD_BITS-1:0];
      y1_q    <= pos.row_sum[COORD_BITS-1:0];
      out1_q  <= pos.col_sum >= {1'b0, cfg.frame_width};
      last1_q <= pos.last;
      clr1_q  <= cfg.transparency_on && (color_index_i == cfg.transparent_color);
    end
  end

  assign prod = y1_q * cfg.frame_width;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      off2_q  <= 32'(prod) + 32'(x1_q);
      rgb2_q  <= pal_rd;
      out2_q  <= out1_q;
      last2_q <= last1_q;
      clr2_q  <= clr1_q;
    end
  end

  assign out_valid_o     = v2_q;
  assign pixel_x_o       = x2_q;
  assign pixel_y_o       = y2_q;
  assign pixel_offset_o  = off2_q;
  assign red_out_o       = rgb2_q.red;
  assign green_out_o     = rgb2_q.green;
  assign blue_out_o      = rgb2_q.blue;
  assign alpha_out_o     = clr2_q ? AlphaClear : AlphaOpaque;
  assign outside_frame_o = out2_q;
  assign last_pixel_o    = last2_q;

endmodule

// ===== rtl/ir2rgba_checker.sv =====
// Port-level assertions for the indexed raster to RGBA core, bound to the top level.
module ir2rgba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pixel_offset_o,
  input logic [7:0]  alpha_out_o,
  input logic        last_pixel_o
);

  a_alpha_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_out_o == 8'h00) || (alpha_out_o == 8'hff))
    else $error("alpha not 0 or 255");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_offset_o)
      && $stable(last_pixel_o))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind indexed_raster_to_rgba_deinterlace_core ir2rgba_checker u_ir2rgba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_offset_o (pixel_offset_o),
  .alpha_out_o    (alpha_out_o),
  .last_pixel_o   (last_pixel_o)
);
